/* src/csvq_pkg.sv */
`default_nettype none

package csvq_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [7:0] RST_DELIMITER = 8'd44;
  localparam logic [7:0] RST_QUOTE     = 8'd34;
  localparam logic [7:0] RST_ESCAPE    = 8'd34;

  localparam int unsigned SLOTS = 4;

  typedef enum logic [1:0] {
    REG_DELIMITER = 2'd0,
    REG_QUOTE     = 2'd1,
    REG_ESCAPE    = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_index_t;

  typedef enum logic {
    CMD_SCAN = 1'b0,
    CMD_EMIT = 1'b1
  } command_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       field_quoted;
  } out_item_t;

  typedef struct packed {
    logic [7:0] delimiter_char;
    logic [7:0] quote_byte;
    logic [7:0] escape_byte;
  } cfg_t;

  // Slot order: opening quote, escape prefix, data byte, closing quote.
  typedef struct packed {
    logic [SLOTS-1:0]      mask;
    logic [SLOTS-1:0][7:0] bytes;
    logic                  quoted;
  } job_t;

endpackage

`default_nettype wire

/* src/csvq_encode.sv */
`default_nettype none

module csvq_encode
  import csvq_pkg::*;
(
  input  cfg_t     cfg,
  input  in_item_t item,
  input  logic     quote_needed,
  output logic     quote_needed_nxt,
  output job_t     job
);

  logic blank;
  logic special;
  logic prefix_escape;
  logic esc;
  logic emit;

  always_comb begin
    emit          = (item.command == CMD_EMIT);
    blank         = (item.data_byte == CH_SPACE) || (item.data_byte == CH_TAB);
    special       = (item.data_byte == cfg.delimiter_char) ||
                    (item.data_byte == cfg.quote_byte) ||
                    (item.data_byte == cfg.escape_byte) ||
                    (item.data_byte == CH_LF) || (item.data_byte == CH_CR);
    prefix_escape = (cfg.escape_byte != cfg.quote_byte);
    esc           = (item.data_byte == cfg.quote_byte) ||
                    (prefix_escape && (item.data_byte == cfg.escape_byte));

    // Scan: restart on the first byte, then accumulate.
    quote_needed_nxt = quote_needed;
    if (!emit) begin
      quote_needed_nxt = (quote_needed && !item.first_byte) ||
                         (blank && (item.first_byte || item.last_byte)) || special;
    end

    job.quoted   = quote_needed;
    job.bytes[0] = cfg.quote_byte;
    job.bytes[1] = cfg.escape_byte;
    job.bytes[2] = item.data_byte;
    job.bytes[3] = cfg.quote_byte;
    job.mask[0]  = emit && quote_needed && item.first_byte;
    job.mask[1]  = emit && quote_needed && esc;
    job.mask[2]  = emit;
    job.mask[3]  = emit && quote_needed && item.last_byte;
  end

endmodule

`default_nettype wire

/* src/csv_field_quoter.sv */
// An emit byte is stored in the job register, which hands its 1 to 4 output bytes
// to the single output register in order; that register drains one byte per cycle
// unless out_stall holds it. Scan bytes produce no output bytes.
// Reset (rst_n low, synchronous): registers return to ',' '"' '"', the quote flag
// clears and any pending output is dropped.
`default_nettype none

module csv_field_quoter
  import csvq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       quote_needed_r;
  logic       quote_needed_nxt;
  job_t       job_r;
  job_t       job_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic             advance;
  logic             in_take;
  logic [SLOTS-1:0] mask_rest;
  logic [7:0]       slot_byte;

  csvq_encode u_encode (
    .cfg              (cfg_r),
    .item             (in_data),
    .quote_needed     (quote_needed_r),
    .quote_needed_nxt (quote_needed_nxt),
    .job              (job_nxt)
  );

  // Output register may load when it is empty or its byte transfers now.
  assign advance = !out_valid_r || !out_stall;

  // Drop the lowest pending slot; that one goes to the output register.
  assign mask_rest = job_r.mask & (job_r.mask - SLOTS'(1));

  // Hold the input while the job still has slots after this cycle's move.
  assign in_stall = (job_r.mask != '0) && !(advance && (mask_rest == '0));
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    priority if (job_r.mask[0]) begin
      slot_byte = job_r.bytes[0];
    end else if (job_r.mask[1]) begin
      slot_byte = job_r.bytes[1];
    end else if (job_r.mask[2]) begin
      slot_byte = job_r.bytes[2];
    end else begin
      slot_byte = job_r.bytes[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delimiter_char <= RST_DELIMITER;
      cfg_r.quote_byte     <= RST_QUOTE;
      cfg_r.escape_byte    <= RST_ESCAPE;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_DELIMITER: cfg_r.delimiter_char <= cfg_wdata;
        REG_QUOTE:     cfg_r.quote_byte     <= cfg_wdata;
        REG_ESCAPE:    cfg_r.escape_byte    <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_needed_r <= 1'b0;
    end else if (in_take) begin
      quote_needed_r <= quote_needed_nxt;
    end
  end

  // Job register: the pending output bytes of the item in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r.mask <= '0;
    end else if (in_take) begin
      job_r.mask   <= job_nxt.mask;
      job_r.bytes  <= job_nxt.bytes;
      job_r.quoted <= job_nxt.quoted;
    end else if (advance) begin
      job_r.mask <= mask_rest;
    end
  end

  // Output register: advance one slot per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= (job_r.mask != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (job_r.mask != '0)) begin
      out_data_r.out_byte     <= slot_byte;
      out_data_r.run_last     <= (mask_rest == '0);
      out_data_r.field_quoted <= job_r.quoted;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* src/csv_field_quoter_chk.sv */
`default_nettype none

module csv_field_quoter_chk
  import csvq_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // Reset drops pending output.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An unquoted byte goes out alone.
  a_plain_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.field_quoted |-> out_data.run_last)
    else $error("unquoted byte with more than one output");

  // Bytes of one run follow without gaps and share the quote flag.
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_last |=>
      out_valid && (out_data.field_quoted == $past(out_data.field_quoted)))
    else $error("run broken or quote flag changed inside a run");

endmodule

bind csv_field_quoter csv_field_quoter_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* verif/csv_field_quoter_tb.sv */
`default_nettype none

module csv_field_quoter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csvq_pkg::*;

  // Run length guard and block timing.
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;     // settle margin before a register write
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int MAX_REPORTS   = 10;

  typedef logic [7:0] byte_q_t[$];

  // Block ports. Every input starts at a known value.
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we    = 1'b0;
  logic [1:0] cfg_index = REG_DELIMITER;
  logic [7:0] cfg_wdata = '0;

  // Predictor state: our own copy of the registers and the quote flag.
  logic [7:0] delim_reg  = RST_DELIMITER;
  logic [7:0] quote_reg  = RST_QUOTE;
  logic [7:0] escape_reg = RST_ESCAPE;
  logic       quote_flag = 1'b0;

  // Encoded bytes still owed by the block, oldest first.
  out_item_t  encoded_bytes[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int items_sent     = 0;

  // Idle rates in percent, per side.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Hold-off requests: the test bumps hold_count, the receiver counts down on its own.
  int hold_count = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  csv_field_quoter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_count) begin
      hold_seen <= hold_count;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic out_item_t make_byte(logic [7:0] b, logic quoted);
    out_item_t r;
    r.out_byte     = b;
    r.run_last     = 1'b0;
    r.field_quoted = quoted;
    return r;
  endfunction

  // Encode one accepted item: a scan byte updates the quote flag, an emit byte
  // queues the 1 to 4 bytes it produces.
  function automatic void encode_item(in_item_t item);
    out_item_t run[$];
    logic      blank;
    logic      special;
    logic      needs_escape;
    blank   = (item.data_byte == CH_SPACE) || (item.data_byte == CH_TAB);
    special = (item.data_byte == delim_reg) || (item.data_byte == quote_reg) ||
              (item.data_byte == escape_reg) || (item.data_byte == CH_LF) ||
              (item.data_byte == CH_CR);
    if (item.command == CMD_SCAN) begin
      // A first byte starts the field afresh; later bytes OR onto the flag.
      if (item.first_byte) quote_flag = 1'b0;
      if ((blank && (item.first_byte || item.last_byte)) || special) quote_flag = 1'b1;
      return;
    end
    if (!quote_flag) begin
      run.push_back(make_byte(item.data_byte, 1'b0));
    end else begin
      // Escape the quote, and in prefix mode the escape character too.
      needs_escape = (item.data_byte == quote_reg) ||
                     ((escape_reg != quote_reg) && (item.data_byte == escape_reg));
      if (item.first_byte) run.push_back(make_byte(quote_reg, 1'b1));
      if (needs_escape) run.push_back(make_byte(escape_reg, 1'b1));
      run.push_back(make_byte(item.data_byte, 1'b1));
      if (item.last_byte) run.push_back(make_byte(quote_reg, 1'b1));
    end
    run[run.size() - 1].run_last = 1'b1;
    foreach (run[i]) encoded_bytes.push_back(run[i]);
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", what);
  endtask

  // Compare every output transfer against the oldest expected byte.
  always @(posedge clk) begin : check_output
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (encoded_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output at cycle %0d: byte %02h last %b quoted %b",
                                  cycle_count, out_data.out_byte, out_data.run_last,
                                  out_data.field_quoted));
      end else begin
        want = encoded_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.run_last !== want.run_last ||
            out_data.field_quoted !== want.field_quoted) begin
          report_mismatch($sformatf(
            "mismatch at cycle %0d: expected byte %02h last %b quoted %b, got %02h %b %b",
            cycle_count, want.out_byte, want.run_last, want.field_quoted,
            out_data.out_byte, out_data.run_last, out_data.field_quoted));
        end
      end
    end
  end

  // Offer one item, optionally after a random gap, and hold it until it transfers.
  task automatic send_item(in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_item(item);
    items_sent++;
  endtask

  function automatic in_item_t make_item(logic cmd, logic [7:0] b, logic first, logic last);
    in_item_t it;
    it.command    = cmd;
    it.data_byte  = b;
    it.first_byte = first;
    it.last_byte  = last;
    return it;
  endfunction

  // Drop valid and wait until every expected byte has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (encoded_bytes.size() != 0) @(posedge clk);
  endtask

  // Write one register once the block is idle.
  task automatic write_reg(reg_index_t idx, logic [7:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_DELIMITER: delim_reg  = value;
      REG_QUOTE:     quote_reg  = value;
      REG_ESCAPE:    escape_reg = value;
      default: ;
    endcase
  endtask

  task automatic write_dialect(logic [7:0] delim, logic [7:0] quote, logic [7:0] esc);
    write_reg(REG_DELIMITER, delim);
    write_reg(REG_QUOTE, quote);
    write_reg(REG_ESCAPE, esc);
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Full field: scan pass then emit pass over the same bytes.
  task automatic send_field(byte_q_t bytes);
    foreach (bytes[i])
      send_item(make_item(CMD_SCAN, bytes[i], i == 0, i == bytes.size() - 1));
    foreach (bytes[i])
      send_item(make_item(CMD_EMIT, bytes[i], i == 0, i == bytes.size() - 1));
  endtask

  // Favor the bytes that drive quoting and escaping.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0:       return delim_reg;
      1:       return quote_reg;
      2:       return escape_reg;
      3:       return CH_SPACE;
      4:       return CH_TAB;
      5:       return CH_CR;
      6:       return CH_LF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Emit before any scan: the flag is clear after reset, so the byte passes as is.
  task automatic test_emit_after_reset();
    send_item(make_item(CMD_EMIT, 8'hFF, 1'b1, 1'b1));
  endtask

  // Single quote byte in the doubling dialect: open, escape, data, close.
  task automatic test_doubled_quote();
    send_field('{RST_QUOTE});
  endtask

  // Leading space forces quoting; a space inside the field does not.
  task automatic test_blank_edges();
    send_field('{CH_SPACE, 8'h00, 8'h61});
    send_field('{8'h61, CH_SPACE, 8'h62});
  endtask

  // A scan byte without a first byte ORs onto the flag of the field before it.
  task automatic test_scan_continuation();
    send_item(make_item(CMD_SCAN, 8'h7A, 1'b1, 1'b1));
    send_item(make_item(CMD_SCAN, RST_DELIMITER, 1'b0, 1'b0));
    send_item(make_item(CMD_EMIT, 8'h7A, 1'b1, 1'b1));
  endtask

  // Prefix mode: the escape character itself gets escaped.
  task automatic test_prefix_escape();
    write_reg(REG_ESCAPE, 8'h5C);
    send_field('{8'h5C});
  endtask

  // Extreme register values, plus a write to the unused index.
  task automatic test_register_extremes();
    write_dialect(8'h00, 8'hFF, 8'h00);
    write_reg(REG_UNUSED, 8'h5A);
    send_field('{8'h00});
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // then pause the sender until every byte has drained and send one short field.
  task automatic test_backpressure();
    byte_q_t bytes;
    for (int i = 0; i < 12; i++) bytes.push_back(i == 3 ? quote_reg : pick_byte());
    hold_count <= hold_count + 1;
    send_field(bytes);
    wait_drained();
    send_field('{quote_reg, 8'h41});
  endtask

  // Mostly well-formed fields with random content; the rest is emit-only
  // runs, truncated scans and loose items.
  task automatic random_traffic(int n_items);
    int      start;
    int      len;
    int      kind;
    byte_q_t bytes;
    start = items_sent;
    while (items_sent - start < n_items) begin
      kind = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 4);
      bytes.delete();
      for (int i = 0; i < len; i++) bytes.push_back(pick_byte());
      if (kind < 75) begin
        send_field(bytes);
      end else if (kind < 85) begin
        // Emit pass with no matching scan; reuse whatever flag is held.
        foreach (bytes[i])
          send_item(make_item(CMD_EMIT, bytes[i], i == 0, i == len - 1));
      end else if (kind < 92) begin
        // Scan that never sees its last byte, then the emit pass.
        foreach (bytes[i]) send_item(make_item(CMD_SCAN, bytes[i], i == 0, 1'b0));
        foreach (bytes[i])
          send_item(make_item(CMD_EMIT, bytes[i], i == 0, i == len - 1));
      end else begin
        send_item(make_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), 1'($urandom_range(1))));
      end
    end
  endtask

  initial begin
    // Hold reset low at start, then release.
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(8, 46);
    test_emit_after_reset();
    test_doubled_quote();
    test_blank_edges();
    test_scan_continuation();
    test_prefix_escape();
    test_register_extremes();

    write_dialect(RST_DELIMITER, RST_QUOTE, RST_ESCAPE);
    random_traffic(40);

    write_dialect(8'hFF, 8'h27, 8'h5C);
    set_idle(46, 8);
    random_traffic(40);

    set_idle(0, 0);
    write_dialect(8'($urandom_range(255)), 8'($urandom_range(255)), 8'h00);
    if ($urandom_range(1)) write_reg(REG_ESCAPE, quote_reg);
    test_backpressure();
    random_traffic(30);

    wait_drained();
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    if (mismatch_count == 0 && encoded_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
